[sv/mhjs_pkg.sv]
package mhjs_pkg;

    localparam int MAX_WORKERS = 64;
    localparam int AW          = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CW          = $clog2(MAX_WORKERS + 1);
    localparam int TIME_W      = 48;
    localparam int DUR_W       = 32;
    localparam int TC_W        = 7;
    localparam int WID_W       = 6;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // one heap slot: free time, then worker index as tie break
    typedef struct packed {
        logic [TIME_W-1:0] free_time;
        logic [AW-1:0]     worker;
    } entry_t;

    // request from the control side to the heap sequencer
    typedef struct packed {
        logic             go;
        logic             replace;
        logic [DUR_W-1:0] dur;
        logic [AW-1:0]    pos;
        logic [CW-1:0]    size;
    } cmd_t;

    // status back from the heap sequencer
    typedef struct packed {
        logic              busy;
        logic              top_valid;
        logic [AW-1:0]     top_worker;
        logic [TIME_W-1:0] top_time;
    } stat_t;

endpackage

[sv/mhjs_cmp.sv]
module mhjs_cmp (
    input  mhjs_pkg::entry_t a,
    input  mhjs_pkg::entry_t b,
    output logic             a_lt_b
);

    // lexicographic order on (free time, worker)
    always_comb
    begin
        if (a.free_time != b.free_time)
        begin
            a_lt_b = (a.free_time < b.free_time);
        end
        else
        begin
            a_lt_b = (a.worker < b.worker);
        end
    end

endmodule

[sv/mhjs_heap_seq.sv]
module mhjs_heap_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  mhjs_pkg::cmd_t  cmd,
    output mhjs_pkg::stat_t stat
);

    localparam int AW = mhjs_pkg::AW;
    localparam int CW = mhjs_pkg::CW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_RD  = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_TOP    = 3'd3;
    localparam logic [2:0] S_DN_RD  = 3'd4;
    localparam logic [2:0] S_DN_LR  = 3'd5;
    localparam logic [2:0] S_DN_CMP = 3'd6;

    mhjs_pkg::entry_t heap_mem [mhjs_pkg::MAX_WORKERS];

    logic [2:0]       state_reg, state_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    size_reg, size_next;
    mhjs_pkg::entry_t cur_reg, cur_next;
    mhjs_pkg::entry_t child_reg, child_next;
    logic [AW-1:0]    child_pos_reg, child_pos_next;

    mhjs_pkg::entry_t rd0_reg, rd1_reg;
    logic [AW-1:0]    rd_addr0, rd_addr1;
    logic             we;
    logic [AW-1:0]    waddr;
    mhjs_pkg::entry_t wdata;

    mhjs_pkg::entry_t cmp_a, cmp_b;
    logic             cmp_lt;

    logic [AW:0]          left_idx;
    logic [AW+1:0]        right_idx;
    logic                 left_ok, right_ok;
    logic [AW-1:0]        parent_idx;
    logic [mhjs_pkg::TIME_W:0] sum;

    assign left_idx   = {pos_reg, 1'b1};
    assign right_idx  = {1'b0, pos_reg, 1'b0} + (AW+2)'(2);
    assign left_ok    = ((AW+2)'(left_idx) < (AW+2)'(size_reg));
    assign right_ok   = (right_idx < (AW+2)'(size_reg));
    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign sum        = {1'b0, rd0_reg.free_time}
                        + (mhjs_pkg::TIME_W+1)'(cur_reg.free_time[mhjs_pkg::DUR_W-1:0]);

    mhjs_cmp u_cmp (
        .a      (cmp_a),
        .b      (cmp_b),
        .a_lt_b (cmp_lt)
    );

    always_comb
    begin
        case (state_reg)
            S_DN_LR:
            begin
                cmp_a = rd1_reg;
                cmp_b = rd0_reg;
            end
            S_DN_CMP:
            begin
                cmp_a = child_reg;
                cmp_b = cur_reg;
            end
            default:
            begin
                cmp_a = cur_reg;
                cmp_b = rd0_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        size_next      = size_reg;
        cur_next       = cur_reg;
        child_next     = child_reg;
        child_pos_next = child_pos_reg;
        rd_addr0       = '0;
        rd_addr1       = right_idx[AW-1:0];
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.go)
                begin
                    cur_next.free_time = mhjs_pkg::TIME_W'(cmd.dur);
                    cur_next.worker    = cmd.pos;
                    size_next          = cmd.size;
                    if (cmd.replace)
                    begin
                        pos_next   = '0;
                        state_next = S_TOP;
                    end
                    else
                    begin
                        pos_next   = cmd.pos;
                        state_next = S_UP_RD;
                    end
                end
            end
            S_UP_RD:
            begin
                rd_addr0 = parent_idx;
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                we = 1'b1;
                if (cmp_lt)
                begin
                    // parent moves down into the hole
                    wdata      = rd0_reg;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_TOP:
            begin
                cur_next.worker    = rd0_reg.worker;
                cur_next.free_time = sum[mhjs_pkg::TIME_W] ? mhjs_pkg::TIME_MAX
                                                           : sum[mhjs_pkg::TIME_W-1:0];
                state_next         = S_DN_RD;
            end
            S_DN_RD:
            begin
                rd_addr0 = left_idx[AW-1:0];
                if (left_ok)
                begin
                    state_next = S_DN_LR;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DN_LR:
            begin
                if (right_ok && cmp_lt)
                begin
                    child_next     = rd1_reg;
                    child_pos_next = right_idx[AW-1:0];
                end
                else
                begin
                    child_next     = rd0_reg;
                    child_pos_next = left_idx[AW-1:0];
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                we = 1'b1;
                if (cmp_lt)
                begin
                    // smaller child moves up into the hole
                    wdata      = child_reg;
                    pos_next   = child_pos_reg;
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        size_reg      <= size_next;
        cur_reg       <= cur_next;
        child_reg     <= child_next;
        child_pos_reg <= child_pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            heap_mem[waddr] <= wdata;
        end
        rd0_reg <= heap_mem[rd_addr0];
        rd1_reg <= heap_mem[rd_addr1];
    end

    assign stat.busy       = (state_reg != S_IDLE);
    assign stat.top_valid  = (state_reg == S_TOP);
    assign stat.top_worker = rd0_reg.worker;
    assign stat.top_time   = rd0_reg.free_time;

endmodule

[sv/min_heap_job_scheduler_core.sv]
// channel   | ports                        | handshake
// ----------+------------------------------+------------------------------------
// job in    | start, job_duration          | taken when start is high, busy low
// result    | done, worker_index,          | one-cycle strobe, no back pressure
//           | start_time                   |
// config    | cfg_we, cfg_data             | written when cfg_we is high
//
// a zero-duration fill job is answered at once and leaves the heap alone; any
// other fill job is answered at once and climbs from its slot (read parent,
// compare, move parent down) to the root or until it stops; a job once all
// workers are in use replaces the root and sinks (read children, pick the
// smaller, compare, move it up) in the compare/swap loop over the heap memory
// (one write and two registered reads per cycle), to a leaf or until it stops.
// reset clears control state only; heap contents are written before use.
// results cannot be stalled: each one is shown for exactly one cycle.
module min_heap_job_scheduler_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mhjs_pkg::TC_W-1:0]     cfg_data,
    input  logic                          start,
    input  logic [mhjs_pkg::DUR_W-1:0]    job_duration,
    output logic                          busy,
    output logic                          done,
    output logic [mhjs_pkg::WID_W-1:0]    worker_index,
    output logic [mhjs_pkg::TIME_W-1:0]   start_time
);

    localparam int AW = mhjs_pkg::AW;
    localparam int CW = mhjs_pkg::CW;

    logic [mhjs_pkg::TC_W-1:0]   thread_count_reg, thread_count_next;
    logic [CW-1:0]               filled_reg, filled_next;
    logic [CW-1:0]               n_active;
    logic                        accept;
    logic                        filling;

    mhjs_pkg::cmd_t              cmd_reg, cmd_next;
    mhjs_pkg::stat_t             stat;

    logic                        done_reg, done_next;
    logic [mhjs_pkg::WID_W-1:0]  worker_reg, worker_next;
    logic [mhjs_pkg::TIME_W-1:0] start_reg, start_next;

    // zero means one worker, anything above MAX_WORKERS saturates
    always_comb
    begin
        if (thread_count_reg == '0)
        begin
            n_active = CW'(1);
        end
        else if (int'(thread_count_reg) > mhjs_pkg::MAX_WORKERS)
        begin
            n_active = CW'(mhjs_pkg::MAX_WORKERS);
        end
        else
        begin
            n_active = CW'(thread_count_reg);
        end
    end

    assign busy    = cmd_reg.go | stat.busy;
    assign accept  = start & ~busy;
    assign filling = (filled_reg < n_active);

    mhjs_heap_seq u_heap (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_reg),
        .stat  (stat)
    );

    // control: register, fill count, heap request pulse, result payload
    always_comb
    begin
        thread_count_next = thread_count_reg;
        filled_next       = filled_reg;
        cmd_next          = cmd_reg;
        cmd_next.go       = 1'b0;
        done_next         = stat.top_valid;
        worker_next       = worker_reg;
        start_next        = start_reg;

        if (accept)
        begin
            cmd_next.replace = ~filling;
            cmd_next.dur     = job_duration;
            cmd_next.pos     = filled_reg[AW-1:0];
            cmd_next.size    = n_active;
            if (filling)
            begin
                worker_next = mhjs_pkg::WID_W'(filled_reg[AW-1:0]);
                start_next  = '0;
            end
        end
        if (stat.top_valid)
        begin
            // heap top serves the job
            worker_next = mhjs_pkg::WID_W'(stat.top_worker);
            start_next  = stat.top_time;
        end

        if (cfg_we)
        begin
            // new worker count restarts scheduling from time zero
            thread_count_next = cfg_data;
            filled_next       = '0;
        end
        else if (accept)
        begin
            if (filling)
            begin
                // fill result is known at once
                done_next = 1'b1;
                if (job_duration != '0)
                begin
                    cmd_next.go = 1'b1;
                    filled_next = filled_reg + CW'(1);
                end
            end
            else
            begin
                cmd_next.go = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thread_count_reg <= mhjs_pkg::TC_W'(1);
            filled_reg       <= '0;
            cmd_reg          <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            thread_count_reg <= thread_count_next;
            filled_reg       <= filled_next;
            cmd_reg          <= cmd_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        worker_reg <= worker_next;
        start_reg  <= start_next;
    end

    assign done         = done_reg;
    assign worker_index = worker_reg;
    assign start_time   = start_reg;

    // fill count never runs past the active worker count
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= n_active)
        else $error("fill count above active workers");

    // zero-duration fill job answers next cycle at time zero and stays idle
    a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_we && filling && job_duration == '0)
        |=> (done && start_time == '0 && !busy))
        else $error("zero-duration fill job mishandled");

    // a job served from the heap top is still busy and not answered yet
    a_replace_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_we && !filling) |=> (busy && !done))
        else $error("heap job answered too early");

endmodule
